>>> hw/rtl/sps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and helper functions of the SWD pin scan unit.
// ----------------------------------------------------------------------------
package sps_pkg;

    // probe channel width of the ports and default channel count
    localparam int PORT_CH      = 16;
    localparam int CH_W         = 4;
    localparam int CHANNELS_DEF = 16;
    localparam int ID_W         = 32;
    localparam int CNT_W        = 5;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    // bit sequence of one round
    localparam logic [15:0] SWITCH_WORD   = 16'he79e;
    localparam logic [7:0]  READ_REQ      = 8'ha5;
    localparam logic [7:0]  RESET_TICKS   = 8'd60;
    localparam logic [7:0]  IDLE_TICKS    = 8'd16;
    localparam logic [7:0]  SWITCH_END    = RESET_TICKS + 8'd16;
    localparam logic [7:0]  RESET2_END    = RESET_TICKS + SWITCH_END;
    localparam logic [7:0]  IDLE_END      = RESET2_END + IDLE_TICKS;
    localparam logic [7:0]  PH_TURN       = IDLE_END + 8'd8;
    localparam logic [7:0]  PH_ACK_FIRST  = PH_TURN + 8'd1;
    localparam logic [7:0]  PH_ACK_LAST   = PH_ACK_FIRST + 8'd2;
    localparam logic [7:0]  PH_ID_FIRST   = PH_ACK_LAST + 8'd1;
    localparam logic [7:0]  PH_ID_LAST    = PH_ID_FIRST + 8'd31;
    localparam logic [7:0]  PH_LAST       = PH_ID_LAST + 8'd1;
    // expected ack bits, first in time at bit 0
    localparam logic [2:0]  ACK_PATTERN   = 3'b001;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    typedef enum logic {
        KIND_DRIVE  = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_SKIP_MASK     = 3'd1,
        REG_INPUT_TYPE    = 3'd2,
        REG_RELEASE       = 3'd3,
        REG_NORMAL_MODE   = 3'd4
    } t_reg;

    // channel groups derived from the configuration
    typedef struct packed {
        logic [PORT_CH-1:0] active;
        logic [PORT_CH-1:0] usable;
        logic [PORT_CH-1:0] releasable;
    } t_masks;

    // per tick control broadcast to the lanes
    typedef struct packed {
        logic       tick;
        logic [7:0] phase;
    } t_lane_ctl;

    typedef struct packed {
        t_kind              kind;
        logic [CH_W-1:0]    probe_clk;
        logic [PORT_CH-1:0] drive_levels;
        logic [PORT_CH-1:0] output_enable;
        logic [CH_W-1:0]    io_channel;
        logic [ID_W-1:0]    idcode;
        logic               scan_done;
        logic               any_found;
        logic               last;
    } t_beat;

    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] idx;
    } t_pick;

    function automatic logic drive_bit(input logic [7:0] p);
        logic [7:0] d;
        logic       b;
        d = 8'd0;
        if (p < RESET_TICKS) begin
            b = 1'b1;
        end else if (p < SWITCH_END) begin
            d = p - RESET_TICKS;
            b = SWITCH_WORD[d[3:0]];
        end else if (p < RESET2_END) begin
            b = 1'b1;
        end else if (p < IDLE_END) begin
            b = 1'b0;
        end else begin
            d = p - IDLE_END;
            b = READ_REQ[d[2:0]];
        end
        return b;
    endfunction

    // lowest set bit of a channel mask
    function automatic t_pick lowest_set(input logic [PORT_CH-1:0] m);
        t_pick r;
        r.hit = |m;
        r.idx = '0;
        for (int i = PORT_CH - 1; i >= 0; i--) begin
            if (m[i]) begin
                r.idx = CH_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sps_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_cfg
// APB register file and derivation of the active, usable and releasable masks.
// ----------------------------------------------------------------------------
module sps_cfg #(
    parameter int P_CHANNELS = sps_pkg::CHANNELS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [sps_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [sps_pkg::PDATA_W-1:0] i_pwdata,
    output logic      [sps_pkg::PDATA_W-1:0] o_prdata,
    output logic                             o_pready,
    output sps_pkg::t_masks                  o_masks
);

    localparam int LANES = (P_CHANNELS < sps_pkg::PORT_CH) ? P_CHANNELS : sps_pkg::PORT_CH;

    logic [sps_pkg::CNT_W-1:0]   r_channel_count;
    logic [sps_pkg::PORT_CH-1:0] r_skip_mask;
    logic [sps_pkg::PORT_CH-1:0] r_input_type_mask;
    logic [sps_pkg::PORT_CH-1:0] r_release_mask;
    logic                        r_normal_mode;
    logic                        w_wr;
    sps_pkg::t_reg               w_reg;
    logic [sps_pkg::PORT_CH-1:0] w_active;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_reg    = sps_pkg::t_reg'(i_paddr[sps_pkg::PADDR_W-1:2]);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= sps_pkg::CNT_W'(sps_pkg::PORT_CH);
            r_skip_mask       <= '0;
            r_input_type_mask <= '1;
            r_release_mask    <= '1;
            r_normal_mode     <= 1'b1;
        end else if (w_wr) begin
            case (w_reg)
                sps_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_pwdata[sps_pkg::CNT_W-1:0];
                sps_pkg::REG_SKIP_MASK:     r_skip_mask <= i_pwdata[sps_pkg::PORT_CH-1:0];
                sps_pkg::REG_INPUT_TYPE:    r_input_type_mask <= i_pwdata[sps_pkg::PORT_CH-1:0];
                sps_pkg::REG_RELEASE:       r_release_mask <= i_pwdata[sps_pkg::PORT_CH-1:0];
                sps_pkg::REG_NORMAL_MODE:   r_normal_mode <= i_pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            sps_pkg::REG_CHANNEL_COUNT: o_prdata = sps_pkg::PDATA_W'(r_channel_count);
            sps_pkg::REG_SKIP_MASK:     o_prdata = sps_pkg::PDATA_W'(r_skip_mask);
            sps_pkg::REG_INPUT_TYPE:    o_prdata = sps_pkg::PDATA_W'(r_input_type_mask);
            sps_pkg::REG_RELEASE:       o_prdata = sps_pkg::PDATA_W'(r_release_mask);
            sps_pkg::REG_NORMAL_MODE:   o_prdata = sps_pkg::PDATA_W'(r_normal_mode);
            default:                    o_prdata = '0;
        endcase
    end

    // channels below the count that exist in this build and are not skipped
    always_comb begin
        for (int i = 0; i < sps_pkg::PORT_CH; i++) begin
            w_active[i] = (i < LANES) && (sps_pkg::CNT_W'(i) < r_channel_count)
                          && !r_skip_mask[i];
        end
        o_masks.active     = w_active;
        o_masks.usable     = r_normal_mode ? (w_active & r_input_type_mask) : w_active;
        o_masks.releasable = r_normal_mode ? (w_active & r_release_mask) : w_active;
    end

endmodule
`default_nettype wire

>>> hw/rtl/sps_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_lane
// One probe channel: ack check, idcode shift register and parity check.
// ----------------------------------------------------------------------------
module sps_lane (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire sps_pkg::t_lane_ctl       i_ctl,
    input  wire logic                     i_sample_en,
    input  wire logic                     i_level,
    output logic                          o_found,
    output logic [sps_pkg::ID_W-1:0]      o_id
);

    logic                    r_ack;
    logic                    n_ack;
    logic [sps_pkg::ID_W-1:0] r_id;
    logic [sps_pkg::ID_W-1:0] n_id;
    logic                    w_live;

    assign w_live = i_sample_en && r_ack;
    assign o_id   = r_id;

    always_comb begin
        logic [7:0] off;
        off     = i_ctl.phase - sps_pkg::PH_ACK_FIRST;
        n_ack   = r_ack;
        n_id    = r_id;
        o_found = 1'b0;
        if (i_ctl.tick) begin
            if (i_ctl.phase == 8'd0) begin
                n_ack = 1'b1;
                n_id  = '0;
            end else if (i_ctl.phase >= sps_pkg::PH_ACK_FIRST &&
                         i_ctl.phase <= sps_pkg::PH_ACK_LAST) begin
                if (w_live) begin
                    n_ack = (i_level == sps_pkg::ACK_PATTERN[off[1:0]]);
                end
            end else if (i_ctl.phase >= sps_pkg::PH_ID_FIRST &&
                         i_ctl.phase <= sps_pkg::PH_ID_LAST) begin
                if (w_live) begin
                    n_id = {i_level, r_id[sps_pkg::ID_W-1:1]};
                end
            end else if (i_ctl.phase == sps_pkg::PH_LAST) begin
                // even parity over idcode and parity bit
                o_found = w_live && ((^r_id) == i_level);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack <= 1'b1;
        end else begin
            r_ack <= n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule
`default_nettype wire

>>> hw/rtl/sps_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_merge
// Output register; merges the lanes' found flags into report beats that
// follow the drive beat in ascending channel order.
// ----------------------------------------------------------------------------
module sps_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire sps_pkg::t_beat              i_beat,
    input  wire logic [sps_pkg::PORT_CH-1:0] i_found,
    input  wire logic [sps_pkg::ID_W-1:0]    i_id [sps_pkg::PORT_CH],
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output sps_pkg::t_beat                   o_beat,
    output logic                             o_can_load
);

    logic                        r_valid;
    logic                        n_valid;
    sps_pkg::t_beat              r_beat;
    sps_pkg::t_beat              n_beat;
    logic [sps_pkg::PORT_CH-1:0] r_rep_mask;
    logic [sps_pkg::PORT_CH-1:0] n_rep_mask;
    logic [sps_pkg::CH_W-1:0]    r_rep_clk;
    logic [sps_pkg::CH_W-1:0]    n_rep_clk;
    logic                        r_rep_done;
    logic                        n_rep_done;
    logic                        w_slot_free;
    sps_pkg::t_pick              w_pick;

    assign w_slot_free = !r_valid || i_out_ready;
    assign w_pick      = sps_pkg::lowest_set(r_rep_mask);
    assign o_can_load  = w_slot_free && (r_rep_mask == '0);
    assign o_out_valid = r_valid;
    assign o_beat      = r_beat;

    always_comb begin
        n_valid    = r_valid && !i_out_ready;
        n_beat     = r_beat;
        n_rep_mask = r_rep_mask;
        n_rep_clk  = r_rep_clk;
        n_rep_done = r_rep_done;
        if (w_slot_free && w_pick.hit) begin
            n_rep_mask               = r_rep_mask & ~(sps_pkg::PORT_CH'(1) << w_pick.idx);
            n_valid                  = 1'b1;
            n_beat.kind              = sps_pkg::KIND_REPORT;
            n_beat.probe_clk         = r_rep_clk;
            n_beat.drive_levels      = '0;
            n_beat.output_enable     = '0;
            n_beat.io_channel        = w_pick.idx;
            n_beat.idcode            = i_id[w_pick.idx];
            n_beat.scan_done         = r_rep_done;
            n_beat.any_found         = 1'b1;
            n_beat.last              = (n_rep_mask == '0);
        end else if (i_load) begin
            n_valid    = 1'b1;
            n_beat     = i_beat;
            n_rep_mask = i_found;
            n_rep_clk  = i_beat.probe_clk;
            n_rep_done = i_beat.scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_rep_mask <= '0;
        end else begin
            r_valid    <= n_valid;
            r_rep_mask <= n_rep_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat     <= n_beat;
        r_rep_clk  <= n_rep_clk;
        r_rep_done <= n_rep_done;
    end

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_rep_mask == '0))
        else $error("new beat loaded while reports pending");

    a_drive_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_found != '0)) |=> (r_valid && !r_beat.last))
        else $error("drive beat marked last ahead of its reports");

    a_last_report_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_beat.kind == sps_pkg::KIND_REPORT && r_beat.last) |-> (r_rep_mask == '0))
        else $error("last report shown with channels still pending");

endmodule
`default_nettype wire

>>> hw/rtl/swd_pin_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pin_scan_unit
// Scans probe channels for an SWD port: per clock candidate a 197 tick round
// of line reset, switch word, line reset, idle and IDCODE read, with one lane per channel
// checking ack, shifting idcode and checking parity.
// ----------------------------------------------------------------------------
//  channel   signals                               dir  beat
//  input     i_in_valid / o_in_ready               in   mode, pin_levels
//  output    o_out_valid / i_out_ready             out  drive beat or report
//  config    psel penable pwrite paddr pwdata      in   APB, zero wait
//
//  a tick beat gives one drive beat in the output register
//  the last tick of a round is followed by one report beat per found channel;
//  they leave one a cycle while the output is taken, and no input beat is taken
//  input is held off while the output register is full and not taken
//  synchronous active low reset; config needs no clearing pass
// ----------------------------------------------------------------------------
module swd_pin_scan_unit #(
    parameter int P_CHANNELS = sps_pkg::CHANNELS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_mode,
    input  wire logic [sps_pkg::PORT_CH-1:0] i_pin_levels,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_kind,
    output logic [sps_pkg::CH_W-1:0]         o_probe_clk,
    output logic [sps_pkg::PORT_CH-1:0]      o_drive_levels,
    output logic [sps_pkg::PORT_CH-1:0]      o_output_enable,
    output logic [sps_pkg::CH_W-1:0]         o_io_channel,
    output logic [sps_pkg::ID_W-1:0]         o_idcode,
    output logic                             o_scan_done,
    output logic                             o_any_found,
    output logic                             o_last,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sps_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sps_pkg::PDATA_W-1:0] pwdata,
    output logic      [sps_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int LANES = (P_CHANNELS < sps_pkg::PORT_CH) ? P_CHANNELS : sps_pkg::PORT_CH;

    sps_pkg::t_masks             w_masks;
    sps_pkg::t_lane_ctl          w_ctl;
    sps_pkg::t_beat              w_beat;
    sps_pkg::t_beat              w_out_beat;
    sps_pkg::t_pick              w_pick_first;
    sps_pkg::t_pick              w_pick_next;
    logic [sps_pkg::PORT_CH-1:0] w_found;
    logic [sps_pkg::ID_W-1:0]    w_id [sps_pkg::PORT_CH];
    logic [sps_pkg::PORT_CH-1:0] w_cbit;
    logic [sps_pkg::PORT_CH-1:0] w_above;
    logic [sps_pkg::PORT_CH-1:0] w_drv;
    logic [sps_pkg::PORT_CH-1:0] w_rel;
    logic [sps_pkg::PORT_CH-1:0] w_smp;
    logic                        w_can_load;
    logic                        w_accept;
    logic                        w_start;
    logic                        w_tick;
    logic                        w_load;
    logic                        w_end_round;
    logic                        w_any_new;

    logic                        r_busy;
    logic                        n_busy;
    logic [7:0]                  r_phase;
    logic [7:0]                  n_phase;
    logic [sps_pkg::CH_W-1:0]    r_clock;
    logic [sps_pkg::CH_W-1:0]    n_clock;
    logic                        r_found_flag;
    logic                        n_found_flag;

    sps_cfg #(
        .P_CHANNELS (P_CHANNELS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_masks   (w_masks)
    );

    assign o_in_ready  = w_can_load;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_start     = w_accept && (i_mode == sps_pkg::MODE_START);
    assign w_tick      = w_accept && (i_mode == sps_pkg::MODE_TICK) && r_busy;
    assign w_end_round = (r_phase == sps_pkg::PH_LAST);

    assign w_cbit  = sps_pkg::PORT_CH'(1) << r_clock;
    assign w_above = ~((w_cbit << 1) - sps_pkg::PORT_CH'(1));
    assign w_drv   = w_masks.usable & ~w_cbit;
    assign w_rel   = w_masks.releasable & ~w_cbit;
    assign w_smp   = w_masks.active & ~w_cbit;

    assign w_pick_first = sps_pkg::lowest_set(w_masks.usable);
    assign w_pick_next  = sps_pkg::lowest_set(w_masks.usable & w_above);

    assign w_ctl.tick  = w_tick;
    assign w_ctl.phase = r_phase;

    genvar g;
    generate
        for (g = 0; g < sps_pkg::PORT_CH; g++) begin : g_lane
            if (g < LANES) begin : g_on
                sps_lane u_lane (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctl       (w_ctl),
                    .i_sample_en (w_smp[g]),
                    .i_level     (i_pin_levels[g]),
                    .o_found     (w_found[g]),
                    .o_id        (w_id[g])
                );
            end else begin : g_off
                assign w_found[g] = 1'b0;
                assign w_id[g]    = '0;
            end
        end
    endgenerate

    assign w_any_new = r_found_flag || (w_found != '0);

    // sequencer and drive beat
    always_comb begin
        n_busy       = r_busy;
        n_phase      = r_phase;
        n_clock      = r_clock;
        n_found_flag = r_found_flag;
        w_load       = 1'b0;

        w_beat.kind          = sps_pkg::KIND_DRIVE;
        w_beat.probe_clk     = r_clock;
        w_beat.io_channel    = '0;
        w_beat.idcode        = '0;
        w_beat.scan_done     = 1'b0;
        w_beat.any_found     = w_any_new;
        w_beat.last          = (w_found == '0);
        if (r_phase < sps_pkg::PH_TURN) begin
            w_beat.output_enable = w_drv;
            w_beat.drive_levels  = sps_pkg::drive_bit(r_phase) ? w_drv : '0;
        end else begin
            // lines that cannot be released keep driving the last request bit
            w_beat.output_enable = w_drv & ~w_rel;
            w_beat.drive_levels  = w_drv & ~w_rel;
        end

        if (w_start) begin
            n_found_flag = 1'b0;
            n_phase      = '0;
            if (w_pick_first.hit) begin
                n_busy  = 1'b1;
                n_clock = w_pick_first.idx;
            end else begin
                n_busy               = 1'b0;
                w_load               = 1'b1;
                w_beat.probe_clk     = '0;
                w_beat.drive_levels  = '0;
                w_beat.output_enable = '0;
                w_beat.scan_done     = 1'b1;
                w_beat.any_found     = 1'b0;
                w_beat.last          = 1'b1;
            end
        end else if (w_tick) begin
            w_load       = 1'b1;
            n_found_flag = w_any_new;
            if (w_end_round) begin
                n_phase = '0;
                if (w_pick_next.hit) begin
                    n_clock = w_pick_next.idx;
                end else begin
                    n_busy           = 1'b0;
                    w_beat.scan_done = 1'b1;
                end
            end else begin
                n_phase = r_phase + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_phase      <= '0;
            r_clock      <= '0;
            r_found_flag <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_phase      <= n_phase;
            r_clock      <= n_clock;
            r_found_flag <= n_found_flag;
        end
    end

    sps_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_beat      (w_beat),
        .i_found     (w_found),
        .i_id        (w_id),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_beat      (w_out_beat),
        .o_can_load  (w_can_load)
    );

    assign o_kind          = w_out_beat.kind;
    assign o_probe_clk     = w_out_beat.probe_clk;
    assign o_drive_levels  = w_out_beat.drive_levels;
    assign o_output_enable = w_out_beat.output_enable;
    assign o_io_channel    = w_out_beat.io_channel;
    assign o_idcode        = w_out_beat.idcode;
    assign o_scan_done     = w_out_beat.scan_done;
    assign o_any_found     = w_out_beat.any_found;
    assign o_last          = w_out_beat.last;

    a_round_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && w_end_round) |=> (r_phase == 8'd0))
        else $error("round did not wrap to phase zero");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_phase == 8'd0 && !r_found_flag))
        else $error("scan start left stale phase or found flag");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output register is stalled");

endmodule
`default_nettype wire
